// File: rtl/page_table_walk_map_translate_assert.svh
// Assertion helpers for the page table engine.
// Both expect i_clk and i_rst_n in the module that uses them.
`ifndef PAGE_TABLE_WALK_MAP_TRANSLATE_ASSERT_SVH
`define PAGE_TABLE_WALK_MAP_TRANSLATE_ASSERT_SVH

// Same-cycle implication.
`define PTW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ptw_pkg.sv
package ptw_pkg;

    localparam int POOL_PAGES_DEF    = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int ADDR_W            = 48;
    localparam int ENTRY_W           = 64;
    localparam int FLAG_W            = 12;
    localparam int FRAME_W           = ADDR_W - FLAG_W;
    localparam int PERM_W            = 3;
    localparam int CFG_IDX_W         = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_ATTR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_FLAG = 2'd2;

    localparam logic [ADDR_W-1:0]  POOL_BASE_RST  = '0;
    localparam logic [ENTRY_W-1:0] LEAF_ATTR_RST  = 64'd1031;
    localparam logic [FLAG_W-1:0]  TABLE_FLAG_RST = 12'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAULT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int PERM_WR_BIT = 1;
    localparam int LEAF_AF_BIT = 6;
    localparam int LEAF_RO_BIT = 7;

    localparam logic [1:0] LVL_LEAF = 2'd3;
    localparam logic [1:0] LVL_LAST = 2'd2;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] vaddr;
        logic [ADDR_W-1:0] paddr;
        logic [PERM_W-1:0] permission;
    } t_ptw_in;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic [1:0]        status;
    } t_ptw_out;

    typedef struct packed {
        logic       clr_step;
        logic       load;
        logic [1:0] level;
        logic       alloc;
        logic       take_ptr;
        logic       leaf_wr;
        logic       set_res;
        logic [1:0] res_status;
        logic       res_leaf;
        logic       push;
    } t_ptw_cmd;

    typedef struct packed {
        logic clr_done;
        logic ent_zero;
        logic ptr_bad;
        logic pool_full;
        logic is_xlate;
        logic out_free;
    } t_ptw_sts;

endpackage

// File: rtl/ptw_ram.sv
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ptw_ctrl.sv
`include "page_table_walk_map_translate_assert.svh"

module ptw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  ptw_pkg::t_ptw_sts i_sts,
    output ptw_pkg::t_ptw_cmd o_cmd,
    output logic              o_idle
);
    import ptw_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_WRLEAF = 3'd4;
    localparam logic [2:0] S_LEAF   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_level, n_level;
    t_ptw_cmd   cmd;

    always_comb begin
        logic       adv;
        logic       fin;
        logic [1:0] fin_st;
        adv     = 1'b0;
        fin     = 1'b0;
        fin_st  = ST_OK;
        n_state = r_state;
        n_level = r_level;
        cmd       = '0;
        cmd.level = r_level;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_level  = '0;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                n_state = (r_level == LVL_LEAF) ? S_LEAF : S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.ent_zero) begin
                    if (i_sts.is_xlate) begin
                        fin    = 1'b1;
                        fin_st = ST_FAULT;
                    end else if (i_sts.pool_full) begin
                        fin    = 1'b1;
                        fin_st = ST_FULL;
                    end else begin
                        cmd.alloc = 1'b1;
                        adv       = 1'b1;
                    end
                end else if (i_sts.ptr_bad) begin
                    fin    = 1'b1;
                    fin_st = ST_FAULT;
                end else begin
                    cmd.take_ptr = 1'b1;
                    adv          = 1'b1;
                end
            end
            S_WRLEAF: begin
                cmd.leaf_wr = 1'b1;
                fin         = 1'b1;
            end
            S_LEAF: begin
                cmd.res_leaf = 1'b1;
                fin          = 1'b1;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.push = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (adv) begin
            if (r_level == LVL_LAST) begin
                n_level = LVL_LEAF;
                n_state = i_sts.is_xlate ? S_READ : S_WRLEAF;
            end else begin
                n_level = r_level + 2'd1;
                n_state = S_READ;
            end
        end
        if (fin) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = fin_st;
            n_state        = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_level <= '0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
        end
    end

    assign o_cmd  = cmd;
    assign o_idle = (r_state == S_IDLE);

    `PTW_ASSERT_NOW(a_check_not_leaf, r_state == S_CHECK, r_level != LVL_LEAF, "check at leaf level")
    `PTW_ASSERT_NEXT(a_accept_walks, (r_state == S_IDLE) && i_in_valid, r_state == S_READ, "accepted word not walked")
    `PTW_ASSERT_NEXT(a_clear_ends, (r_state == S_CLEAR) && i_sts.clr_done, r_state == S_IDLE, "clear pass did not end")

endmodule

// File: rtl/ptw_dpath.sv
`include "page_table_walk_map_translate_assert.svh"

module ptw_dpath #(
    parameter int POOL_PAGES = ptw_pkg::POOL_PAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ptw_pkg::t_ptw_cmd                  i_cmd,
    output ptw_pkg::t_ptw_sts                  o_sts,
    input  ptw_pkg::t_ptw_in                   i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output ptw_pkg::t_ptw_out                  o_out_data,
    input  logic                               i_cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ptw_pkg::ENTRY_W-1:0]        i_cfg_wdata
);
    import ptw_pkg::*;

    localparam int PW    = $clog2(POOL_PAGES);
    localparam int AW    = PW + IDX_W;
    localparam int DEPTH = POOL_PAGES * ENTRIES_PER_TABLE;
    localparam int NW    = $clog2(POOL_PAGES + 1);

    logic                r_func;
    logic [ADDR_W-1:0]   r_va;
    logic [ADDR_W-1:0]   r_pa;
    logic [PERM_W-1:0]   r_perm;
    logic [PW-1:0]       r_page;
    logic [NW-1:0]       r_nfp;
    logic [AW-1:0]       r_clr;
    logic [ADDR_W-1:0]   r_pool_base;
    logic [ENTRY_W-1:0]  r_leaf_attr;
    logic [FLAG_W-1:0]   r_table_flag;
    t_ptw_out            r_res;
    t_ptw_out            r_out;
    logic                r_out_valid;

    logic [IDX_W-1:0]    idx_sel;
    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [ENTRY_W-1:0]  rd_data;
    logic [FRAME_W-1:0]  ptr_diff;
    logic [FRAME_W-1:0]  new_frame;
    logic [ENTRY_W-1:0]  alloc_ent;
    logic [ENTRY_W-1:0]  leaf_ent;
    logic [ENTRY_W-1:0]  rwx;
    t_ptw_sts            sts;

    always_comb begin
        case (i_cmd.level)
            2'd0:    idx_sel = r_va[47:39];
            2'd1:    idx_sel = r_va[38:30];
            2'd2:    idx_sel = r_va[29:21];
            default: idx_sel = r_va[20:12];
        endcase
    end

    // pointer decode relative to pool base, modulo 2^48
    assign ptr_diff  = rd_data[ADDR_W-1:FLAG_W] - r_pool_base[ADDR_W-1:FLAG_W];
    assign new_frame = r_pool_base[ADDR_W-1:FLAG_W] + FRAME_W'(r_nfp);
    assign alloc_ent = {{(ENTRY_W - ADDR_W){1'b0}}, new_frame, r_table_flag};

    always_comb begin
        rwx              = '0;
        rwx[LEAF_AF_BIT] = 1'b1;
        if (r_perm[PERM_WR_BIT]) begin
            rwx[0] = 1'b1;
        end else begin
            rwx[LEAF_RO_BIT] = 1'b1;
        end
    end

    assign leaf_ent = {{(ENTRY_W - ADDR_W){1'b0}}, r_pa} | r_leaf_attr | rwx;

    assign mem_addr = i_cmd.clr_step ? r_clr : {r_page, idx_sel};
    assign mem_we   = i_cmd.clr_step | i_cmd.alloc | i_cmd.leaf_wr;

    always_comb begin
        if (i_cmd.alloc) begin
            mem_wdata = alloc_ent;
        end else if (i_cmd.leaf_wr) begin
            mem_wdata = leaf_ent;
        end else begin
            mem_wdata = '0;
        end
    end

    ptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (rd_data)
    );

    always_comb begin
        sts.clr_done  = (r_clr == AW'(DEPTH - 1));
        sts.ent_zero  = (rd_data == '0);
        sts.ptr_bad   = (ptr_diff >= FRAME_W'(POOL_PAGES));
        sts.pool_full = (r_nfp >= NW'(POOL_PAGES));
        sts.is_xlate  = r_func;
        sts.out_free  = !r_out_valid || !i_out_stall;
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_in_data.func;
            r_va   <= i_in_data.vaddr;
            r_pa   <= i_in_data.paddr;
            r_perm <= i_in_data.permission;
            r_page <= '0;
        end else if (i_cmd.alloc) begin
            r_page <= r_nfp[PW-1:0];
        end else if (i_cmd.take_ptr) begin
            r_page <= ptr_diff[PW-1:0];
        end
        if (i_cmd.set_res) begin
            r_res.status      <= i_cmd.res_status;
            r_res.result_addr <= i_cmd.res_leaf ?
                                 {rd_data[ADDR_W-1:FLAG_W], r_va[FLAG_W-1:0]} : '0;
        end
        if (i_cmd.push) begin
            r_out <= r_res;
        end
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfp        <= NW'(1);
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_pool_base  <= POOL_BASE_RST;
            r_leaf_attr  <= LEAF_ATTR_RST;
            r_table_flag <= TABLE_FLAG_RST;
        end else begin
            if (i_cmd.alloc) begin
                r_nfp <= r_nfp + NW'(1);
            end
            if (i_cmd.clr_step && !sts.clr_done) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POOL_BASE:  r_pool_base  <= i_cfg_wdata[ADDR_W-1:0];
                    CFG_LEAF_ATTR:  r_leaf_attr  <= i_cfg_wdata;
                    CFG_TABLE_FLAG: r_table_flag <= i_cfg_wdata[FLAG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_sts       = sts;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PTW_ASSERT_NOW(a_nfp_range, 1'b1, (r_nfp != '0) && (r_nfp <= NW'(POOL_PAGES)), "free page counter out of range")
    `PTW_ASSERT_NOW(a_alloc_room, i_cmd.alloc, sts.ent_zero && !sts.pool_full && !r_func, "bad page allocation")
    `PTW_ASSERT_NOW(a_push_free, i_cmd.push, sts.out_free, "result pushed over a waiting word")

endmodule

// File: rtl/page_table_walk_map_translate.sv
// Four-level page table engine, 4 KiB granule, with a private pool of table pages.
// Input channel (i_in_valid / o_in_stall / i_in_data): one word is a map or a translate
// request. Output channel (o_out_valid / i_out_stall / o_out_data): one result word per
// request, with the translated address (zero on map or on fault) and a status.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx (pool base, leaf
// attributes, table flag). The user must write only while no request is in flight;
// the block itself does not enforce it. Each table read in the single-port table RAM
// is a state that presents the address and a state that checks the registered data;
// four levels are walked in turn, and a fault ends the walk early. The next request is
// accepted the cycle after the result is handed to the output register.
// Reset: config registers take their reset values and the allocator restarts at page 1.
// The table RAM is then cleared one entry per cycle over all POOL_PAGES*512 entries, while
// o_in_stall stays high; configuration writes are still taken.
// When the receiver stalls, the result is held in the output register and a new request
// is still accepted; a finished walk waits for that register to empty.
module page_table_walk_map_translate #(
    parameter int POOL_PAGES = ptw_pkg::POOL_PAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ptw_pkg::t_ptw_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ptw_pkg::t_ptw_out             o_out_data,
    input  logic                          i_cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ptw_pkg::ENTRY_W-1:0]   i_cfg_wdata
);
    import ptw_pkg::*;

    t_ptw_cmd cmd;
    t_ptw_sts sts;
    logic     idle;

    ptw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    ptw_dpath #(
        .POOL_PAGES (POOL_PAGES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    assign o_in_stall = !idle;

endmodule

// File: verif/page_table_walk_map_translate_tb.sv
module page_table_walk_map_translate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptw_pkg::*;

    localparam int POOL = POOL_PAGES_DEF;
    localparam int OFS_W = 12;
    localparam int QUIET_LIMIT = 100000;   // covers the table clear after reset
    localparam int PHASES = 8;
    localparam int PHASE_WORDS = 250;

    localparam logic FN_MAP   = 1'b0;
    localparam logic FN_XLATE = 1'b1;

    // Shadow copy of the table pool and registers; predicts one result word per request.
    class translation_shadow;
        logic [ENTRY_W-1:0] store [POOL*ENTRIES_PER_TABLE];
        int unsigned        next_page;
        logic [ADDR_W-1:0]  base;
        logic [ENTRY_W-1:0] attr;
        logic [FLAG_W-1:0]  tflag;
        t_ptw_out           due [$];
        int                 miscompares;

        function new();
            foreach (store[i]) store[i] = '0;
            next_page   = 1;
            base        = POOL_BASE_RST;
            attr        = LEAF_ATTR_RST;
            tflag       = TABLE_FLAG_RST;
            miscompares = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ENTRY_W-1:0] val);
            case (idx)
                CFG_POOL_BASE:  base = val[ADDR_W-1:0];
                CFG_LEAF_ATTR:  attr = val;
                CFG_TABLE_FLAG: tflag = val[FLAG_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [ADDR_W-1:0] frame_of(int unsigned pg);
            return {base[ADDR_W-1:OFS_W], {OFS_W{1'b0}}} + (ADDR_W'(pg) << OFS_W);
        endfunction

        function void note_request(t_ptw_in req);
            t_ptw_out           res;
            logic [ADDR_W-1:0]  span;
            logic [ENTRY_W-1:0] ent;
            logic [IDX_W-1:0]   idx [4];
            int unsigned        pg;
            int unsigned        slot_at;
            bit                 stop;
            res  = '0;
            pg   = 0;
            stop = 1'b0;
            for (int l = 0; l < 4; l++)
                idx[l] = req.vaddr[ADDR_W-1-IDX_W*l -: IDX_W];
            for (int l = 0; l < 3 && !stop; l++) begin
                slot_at = pg * ENTRIES_PER_TABLE + idx[l];
                ent = store[slot_at];
                if (ent == '0) begin
                    if (req.func == FN_XLATE) begin
                        res.status = ST_FAULT;
                        stop = 1'b1;
                    end else if (next_page >= POOL) begin
                        res.status = ST_FULL;
                        stop = 1'b1;
                    end else begin
                        // may itself be zero when the base wraps to address 0 and flag is 0
                        ent = ENTRY_W'(frame_of(next_page)) | ENTRY_W'(tflag);
                        next_page++;
                        store[slot_at] = ent;
                    end
                end
                if (!stop) begin
                    span = {ent[ADDR_W-1:OFS_W], {OFS_W{1'b0}}}
                         - {base[ADDR_W-1:OFS_W], {OFS_W{1'b0}}};
                    if (span[ADDR_W-1:OFS_W] >= POOL) begin
                        res.status = ST_FAULT;
                        stop = 1'b1;
                    end else begin
                        pg = span[ADDR_W-1:OFS_W];
                    end
                end
            end
            if (!stop) begin
                slot_at = pg * ENTRIES_PER_TABLE + idx[3];
                if (req.func == FN_MAP) begin
                    ent = ENTRY_W'(req.paddr) | attr | (64'd1 << LEAF_AF_BIT);
                    if (req.permission[PERM_WR_BIT])
                        ent |= 64'd1;
                    else
                        ent |= 64'd1 << LEAF_RO_BIT;
                    store[slot_at] = ent;
                end else begin
                    // leaf itself is not checked: a zero leaf just gives the offset
                    res.result_addr = {store[slot_at][ADDR_W-1:OFS_W],
                                       req.vaddr[OFS_W-1:0]};
                end
            end
            due.push_back(res);
        endfunction

        task flag_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            miscompares++;
        endtask

        task check_result(t_ptw_out got);
            t_ptw_out want;
            if (due.size() == 0) begin
                flag_mismatch($sformatf("result word with none due: addr %h status %0d",
                                        got.result_addr, got.status));
                return;
            end
            want = due.pop_front();
            if (got.result_addr !== want.result_addr)
                flag_mismatch($sformatf("result_addr %h, want %h",
                                        got.result_addr, want.result_addr));
            if (got.status !== want.status)
                flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_ptw_in              in_word;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_ptw_out             out_word;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [ENTRY_W-1:0]   cfg_wdata;

    translation_shadow    shadow;
    int unsigned          in_gap_pct = 0;
    int unsigned          out_stall_pct = 0;
    int unsigned          quiet_cycles = 0;
    logic [IDX_W-1:0]     palette [4][3];
    logic [ADDR_W-1:0]    mapped_va [$];

    page_table_walk_map_translate #(
        .POOL_PAGES(POOL)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    always @(negedge clk) begin
        out_stall = ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            shadow.check_result(out_word);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // mostly indices from a small palette, so walks reuse tables and reach the leaves
    function automatic logic [ADDR_W-1:0] pick_va();
        logic [ADDR_W-1:0] va;
        va = rand48();
        for (int l = 0; l < 4; l++)
            if ($urandom_range(99) < 90)
                va[ADDR_W-1-IDX_W*l -: IDX_W] = palette[l][$urandom_range(2)];
        return va;
    endfunction

    task automatic send_request(t_ptw_in req);
        while ($urandom_range(99) < in_gap_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_word  = req;
        do @(posedge clk); while (in_stall);
        shadow.note_request(req);
        @(negedge clk);
    endtask

    task automatic issue(logic fn, logic [ADDR_W-1:0] va, logic [ADDR_W-1:0] pa,
                         logic [PERM_W-1:0] perm);
        t_ptw_in req;
        req.func       = fn;
        req.vaddr      = va;
        req.paddr      = pa;
        req.permission = perm;
        send_request(req);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (shadow.due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ENTRY_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(posedge clk);
        shadow.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_setting(logic [ADDR_W-1:0] base, logic [ENTRY_W-1:0] attr,
                                 logic [FLAG_W-1:0] flag);
        drain();
        repeat (4) @(negedge clk);
        write_reg(CFG_POOL_BASE, ENTRY_W'(base));
        write_reg(CFG_LEAF_ATTR, attr);
        write_reg(CFG_TABLE_FLAG, ENTRY_W'(flag));
    endtask

    task automatic random_request();
        t_ptw_in     req;
        int unsigned r;
        r = $urandom_range(99);
        req.paddr      = rand48();
        req.permission = PERM_W'($urandom);
        if (r < 45) begin
            req.func  = FN_MAP;
            req.vaddr = pick_va();
            mapped_va.push_back(req.vaddr);
            if (mapped_va.size() > 64)
                void'(mapped_va.pop_front());
        end else if (r < 70 && mapped_va.size() != 0) begin
            req.func  = FN_XLATE;
            req.vaddr = mapped_va[$urandom_range(mapped_va.size() - 1)];
            req.vaddr[OFS_W-1:0] = OFS_W'($urandom);
        end else if (r < 92) begin
            req.func  = FN_XLATE;
            req.vaddr = pick_va();
        end else begin
            req.func  = 1'($urandom);
            req.vaddr = rand48();
        end
        send_request(req);
    endtask

    initial begin
        logic [ADDR_W-1:0]  base;
        logic [ENTRY_W-1:0] attr;
        logic [FLAG_W-1:0]  flag;
        shadow    = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_POOL_BASE;
        cfg_wdata = '0;
        for (int l = 0; l < 4; l++) begin
            palette[l][0] = '0;
            palette[l][1] = '1;
            palette[l][2] = IDX_W'($urandom_range(510, 1));
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // base at the top of the address space: page 1 wraps to 0 and, with no flag,
        // its pointer reads back as empty
        write_reg(CFG_POOL_BASE, '1);
        write_reg(CFG_LEAF_ATTR, '0);
        write_reg(CFG_TABLE_FLAG, '0);
        issue(FN_MAP, '0, '0, 3'b000);
        issue(FN_XLATE, 48'h0000_0000_0abc, '0, 3'b000);
        issue(FN_MAP, '0, '1, 3'b111);

        apply_setting(POOL_BASE_RST, LEAF_ATTR_RST, TABLE_FLAG_RST);
        issue(FN_XLATE, '0, '0, 3'b000);
        issue(FN_MAP, '0, '0, 3'b000);
        issue(FN_XLATE, 48'h0000_0000_0fff, '1, 3'b000);
        issue(FN_XLATE, 48'h0000_0000_5123, '0, 3'b000);        // leaf never written
        issue(FN_MAP, 48'h0000_0000_1000, 48'h1234_5678_9000, 3'b010);
        issue(FN_XLATE, 48'h0000_0000_1abc, '0, 3'b000);
        issue(FN_XLATE, 48'h0000_4000_0000, '0, 3'b000);        // hole at level 1
        issue(FN_XLATE, 48'h0000_0020_0000, '0, 3'b000);        // hole at level 2
        issue(FN_MAP, '1, '1, 3'b111);
        issue(FN_XLATE, '1, '0, 3'b000);
        issue(FN_MAP, 48'haaaa_aaaa_a000, 48'h5555_5555_5555, 3'b101);
        issue(FN_XLATE, 48'haaaa_aaaa_a555, '0, 3'b000);
        issue(FN_MAP, '0, 48'hffff_ffff_f000, 3'b100);          // overwrite a leaf
        issue(FN_XLATE, 48'h0000_0000_0123, '0, 3'b001);
        issue(FN_XLATE, 48'h8000_0000_0000, '0, 3'b110);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                2, 3, 7: base = '1;
                5:       base = rand48();
                default: base = ADDR_W'($urandom_range(4095));  // low bits are ignored
            endcase
            case (p % 3)
                0:       begin attr = '0; flag = '1; end
                1:       begin attr = '1; flag = '0; end
                default: begin attr = {$urandom, $urandom}; flag = FLAG_W'($urandom); end
            endcase
            apply_setting(base, attr, flag);
            case (p % 4)
                0:       begin in_gap_pct = 0;  out_stall_pct = 0;  end
                1:       begin in_gap_pct = 72; out_stall_pct = 0;  end
                2:       begin in_gap_pct = 0;  out_stall_pct = 72; end
                default: begin in_gap_pct = 20; out_stall_pct = 20; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2)
                    drain();
                random_request();
            end
        end

        drain();
        repeat (30) @(posedge clk);
        if (shadow.miscompares == 0 && shadow.due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: page_table_walk_map_translate.f
+incdir+rtl
rtl/ptw_pkg.sv
rtl/ptw_ram.sv
rtl/ptw_ctrl.sv
rtl/ptw_dpath.sv
rtl/page_table_walk_map_translate.sv
verif/page_table_walk_map_translate_tb.sv
